// File: rtl/pndp_pkg.sv
// Shared types, constants and helper functions for the noise dither pixel block.
`default_nettype none

package pndp_pkg;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [6:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic        draw;
        logic [12:0] byte_index;
        logic [1:0]  lane;
        logic [1:0]  pixel_color;
        logic [7:0]  noise_level;
    } t_pix_out;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OFFSET_X = 3'd0;
    localparam logic [2:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [2:0] CFG_SHIFT    = 3'd2;
    localparam logic [2:0] CFG_SCALE    = 3'd3;
    localparam logic [2:0] CFG_COLOR    = 3'd4;

    localparam logic [23:0] SCALE_RESET = 24'd655;
    localparam logic [1:0]  COLOR_RESET = 2'd1;

    localparam logic [31:0] HASH_C1 = 32'd3284157443;
    localparam logic [31:0] HASH_C2 = 32'd1911520717;
    localparam logic [31:0] HASH_C3 = 32'd2048419325;
    localparam logic [63:0] PI_Q30  = 64'd3373259422;

    // Per-octave value width and octave sum width.
    localparam int PW = 38;
    localparam int TW = 40;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return a * b;
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] g);
        return {{16{g[15]}}, g};
    endfunction

    function automatic logic [31:0] mix8(input logic [31:0] a);
        return (a << 8) | (a >> 8);
    endfunction

    // Quarter-wave sine entry in Q1.14, from an integer Taylor series.
    function automatic logic [14:0] sin_q14(input int k, input int bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        int                 n;
        x    = (PI_Q30 * 64'(k)) >> (bits - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1: begin
                    term = term / 64'd6;
                end
                2: begin
                    term = term / 64'd20;
                end
                3: begin
                    term = term / 64'd42;
                end
                4: begin
                    term = term / 64'd72;
                end
                5: begin
                    term = term / 64'd110;
                end
                6: begin
                    term = term / 64'd156;
                end
                default: begin
                    term = term / 64'd210;
                end
            endcase
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (64'(sum) + 64'd32768) >> 16;
        if (q > 64'd16384) begin
            q = 64'd16384;
        end
        return q[14:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/pndp_octave.sv
// One octave of hashed-gradient noise as a nine-stage pipeline.
`default_nettype none

module pndp_octave #(
    parameter int ANG_BITS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic [8:0]                   i_en,
    input  wire logic [31:0]                  i_cx,
    input  wire logic [31:0]                  i_cy,
    output logic signed [pndp_pkg::PW-1:0]    o_p
);
    import pndp_pkg::*;

    localparam int ANG_Q = 1 << (ANG_BITS - 2);
    localparam int KW    = ANG_BITS - 2;

    logic [14:0] w_tab [0:ANG_Q];

    for (genvar g = 0; g <= ANG_Q; g++) begin : g_tab
        assign w_tab[g] = sin_q14(g, ANG_BITS);
    end

    logic [15:0]          r_fx [0:6];
    logic [15:0]          r_fy [0:6];
    logic [31:0]          r_a0 [0:1];
    logic [31:0]          r_a1 [0:1];
    logic [15:0]          r_gy [0:1];
    logic [31:0]          r_b  [0:3];
    logic [ANG_BITS-1:0]  r_idx [0:3];
    logic signed [15:0]   r_c [0:3];
    logic signed [15:0]   r_s [0:3];
    logic signed [33:0]   r_d [0:3];
    logic signed [51:0]   r_pt;
    logic signed [51:0]   r_pb;
    logic signed [33:0]   r_l0;
    logic signed [33:0]   r_l2;
    logic signed [35:0]   r_top;
    logic signed [35:0]   r_bot;
    logic signed [53:0]   r_pv;
    logic signed [35:0]   r_top2;
    logic signed [PW-1:0] r_p;

    logic [15:0] w_gx0;
    logic [15:0] w_gy0;
    logic [31:0] w_h [0:3];

    assign w_gx0 = i_cx[31:16];
    assign w_gy0 = i_cy[31:16];

    // Fractions travel alongside the hash and interpolation stages.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_fx[0] <= i_cx[15:0];
            r_fy[0] <= i_cy[15:0];
        end
        for (int k = 1; k <= 6; k++) begin
            if (i_en[k]) begin
                r_fx[k] <= r_fx[k-1];
                r_fy[k] <= r_fy[k-1];
            end
        end
    end

    // Hash, first round: depends on the column only.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a0[0] <= mul32(sext16(w_gx0), HASH_C1);
            r_a0[1] <= mul32(sext16(w_gx0 + 16'd1), HASH_C1);
            r_gy[0] <= w_gy0;
            r_gy[1] <= w_gy0 + 16'd1;
        end
    end

    // Corner j: bit 0 selects the right column, bit 1 the lower row.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int j = 0; j < 4; j++) begin
                r_b[j] <= mul32(sext16(r_gy[j/2]) ^ mix8(r_a0[j%2]), HASH_C2);
            end
            r_a1[0] <= r_a0[0];
            r_a1[1] <= r_a0[1];
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_h[j] = mul32(r_a1[j%2] ^ mix8(r_b[j]), HASH_C3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int j = 0; j < 4; j++) begin
                r_idx[j] <= w_h[j][31 -: ANG_BITS];
            end
        end
    end

    // Angle to cosine and sine by quadrant folding of the quarter-wave table.
    logic [KW:0]          w_kk [0:3];
    logic [KW:0]          w_km [0:3];
    logic signed [15:0]   w_sa [0:3];
    logic signed [15:0]   w_sb [0:3];
    logic signed [15:0]   w_c  [0:3];
    logic signed [15:0]   w_s  [0:3];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_kk[j] = {1'b0, r_idx[j][KW-1:0]};
            w_km[j] = (KW+1)'(ANG_Q) - w_kk[j];
            w_sa[j] = $signed({1'b0, w_tab[w_kk[j]]});
            w_sb[j] = $signed({1'b0, w_tab[w_km[j]]});
            case (r_idx[j][ANG_BITS-1 -: 2])
                2'd0: begin
                    w_s[j] = w_sa[j];
                    w_c[j] = w_sb[j];
                end
                2'd1: begin
                    w_s[j] = w_sb[j];
                    w_c[j] = -w_sa[j];
                end
                2'd2: begin
                    w_s[j] = -w_sa[j];
                    w_c[j] = -w_sb[j];
                end
                default: begin
                    w_s[j] = -w_sb[j];
                    w_c[j] = w_sa[j];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int j = 0; j < 4; j++) begin
                r_c[j] <= w_c[j];
                r_s[j] <= w_s[j];
            end
        end
    end

    // Distance to the right or lower corner is the fraction minus one.
    logic signed [16:0] w_dx [0:3];
    logic signed [16:0] w_dy [0:3];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_dx[j] = $signed({(j % 2) == 1, r_fx[3]});
            w_dy[j] = $signed({(j / 2) == 1, r_fy[3]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            for (int j = 0; j < 4; j++) begin
                r_d[j] <= w_dx[j] * r_c[j] + w_dy[j] * r_s[j];
            end
        end
    end

    logic signed [34:0] w_dt;
    logic signed [34:0] w_db;
    logic signed [16:0] w_wx;
    logic signed [16:0] w_wy;
    logic signed [36:0] w_dv;
    logic signed [37:0] w_v;

    assign w_dt = r_d[1] - r_d[0];
    assign w_db = r_d[3] - r_d[2];
    assign w_wx = $signed({1'b0, r_fx[4]});
    assign w_wy = $signed({1'b0, r_fy[6]});
    assign w_dv = r_bot - r_top;
    assign w_v  = r_top2 + $signed(r_pv[53:16]);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_pt <= w_dt * w_wx;
            r_pb <= w_db * w_wx;
            r_l0 <= r_d[0];
            r_l2 <= r_d[2];
        end
        if (i_en[6]) begin
            r_top <= r_l0 + $signed(r_pt[51:16]);
            r_bot <= r_l2 + $signed(r_pb[51:16]);
        end
        if (i_en[7]) begin
            r_pv   <= w_dv * w_wy;
            r_top2 <= r_top;
        end
        if (i_en[8]) begin
            r_p <= (w_v >>> 1) + PW'(1 << 29);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: rtl/perlin_noise_dither_pixel.sv
// Top level: coordinate set-up, three noise octaves, level scaling and ordered threshold.
//
//  Channel   Signals                                  Direction  Payload
//  pixel     i_valid / o_ready / i_pixel              in         t_pix_in
//  result    o_valid / i_ready / o_result             out        t_pix_out
//  config    i_cfg_valid / o_cfg_ready / i_cfg_index  in         i_cfg_data
//
// One pixel transaction is taken per clock while o_ready is high.
// The pipeline depth is set by the hash multiplier chain and the two lerp multiply stages.
// Every stage has its own valid bit and moves when the stage after it is free,
// so a stall on the result side fills bubbles first and loses nothing.
// Reset clears the valid bits and loads the configuration defaults.
`default_nettype none

module perlin_noise_dither_pixel #(
    parameter int IMG_WIDTH        = 256,
    parameter int IMG_HEIGHT       = 128,
    parameter int ANGLE_TABLE_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire pndp_pkg::t_pix_in  i_pixel,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output pndp_pkg::t_pix_out      o_result,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    import pndp_pkg::*;

    localparam int NST = 13;

    logic signed [15:0] r_offset_x;
    logic signed [15:0] r_offset_y;
    logic [15:0]        r_shift;
    logic [23:0]        r_scale;
    logic [1:0]         r_color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_shift    <= '0;
            r_scale    <= SCALE_RESET;
            r_color    <= COLOR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFFSET_X: begin
                    r_offset_x <= $signed(i_cfg_data[15:0]);
                end
                CFG_OFFSET_Y: begin
                    r_offset_y <= $signed(i_cfg_data[15:0]);
                end
                CFG_SHIFT: begin
                    r_shift <= i_cfg_data[15:0];
                end
                CFG_SCALE: begin
                    r_scale <= i_cfg_data;
                end
                CFG_COLOR: begin
                    r_color <= i_cfg_data[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Valid bits and per-stage advance.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;

    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NST-1];

    // Pixel coordinates ride along to the final stage.
    t_pix_in r_pix [0:NST-2];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_pix[0] <= i_pixel;
        end
        for (int k = 1; k < NST - 1; k++) begin
            if (w_adv[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
    end

    logic signed [17:0] r_xx;
    logic signed [17:0] r_yy;
    logic signed [42:0] w_px;
    logic signed [42:0] w_qy;
    logic [31:0]        r_p32;
    logic [31:0]        r_q32;

    assign w_px = r_xx * $signed({1'b0, r_scale});
    assign w_qy = r_yy * $signed({1'b0, r_scale});

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_xx <= $signed({10'd0, i_pixel.pixel_x}) + r_offset_x + $signed({2'b0, r_shift});
            r_yy <= $signed({11'd0, i_pixel.pixel_y}) + r_offset_y + $signed({2'b0, r_shift});
        end
        if (w_adv[1]) begin
            r_p32 <= w_px[31:0];
            r_q32 <= w_qy[31:0];
        end
    end

    logic signed [PW-1:0] w_o1;
    logic signed [PW-1:0] w_o2;
    logic signed [PW-1:0] w_o3;

    pndp_octave #(.ANG_BITS(ANGLE_TABLE_BITS)) u_oct1 (
        .i_clk (i_clk),
        .i_en  (w_adv[10:2]),
        .i_cx  (r_p32),
        .i_cy  (r_q32 << 1),
        .o_p   (w_o1)
    );

    pndp_octave #(.ANG_BITS(ANGLE_TABLE_BITS)) u_oct2 (
        .i_clk (i_clk),
        .i_en  (w_adv[10:2]),
        .i_cx  (r_p32 << 2),
        .i_cy  (r_q32 << 2),
        .o_p   (w_o2)
    );

    pndp_octave #(.ANG_BITS(ANGLE_TABLE_BITS)) u_oct3 (
        .i_clk (i_clk),
        .i_en  (w_adv[10:2]),
        .i_cx  (r_p32 << 3),
        .i_cy  (r_q32 << 3),
        .o_p   (w_o3)
    );

    logic signed [TW-1:0] r_t;

    always_ff @(posedge i_clk) begin
        if (w_adv[11]) begin
            r_t <= TW'(w_o1) + TW'(w_o2 >>> 2) + TW'(w_o3 >>> 3);
        end
    end

    // Level is T * 255 / 2^31, clamped to 0..255, formed as a shift and subtract.
    logic [TW+7:0] w_m;
    logic [7:0]    w_level;
    logic [3:0]    w_q;
    logic [8:0]    w_z;
    logic [6:0]    w_mask;
    logic          w_thr;
    logic          w_in_img;
    logic          w_draw;
    logic [31:0]   w_bidx;
    t_pix_in       w_pl;

    assign w_pl = r_pix[NST-2];
    assign w_m  = {r_t, 8'd0} - (TW+8)'(r_t);

    always_comb begin
        if (r_t <= 0) begin
            w_level = 8'd0;
        end else if (w_m[TW+7:31] > (TW-23)'(255)) begin
            w_level = 8'd255;
        end else begin
            w_level = w_m[38:31];
        end
        w_q = w_level[7:4];
        w_z = {1'b0, w_pl.pixel_x} + {2'b0, w_pl.pixel_y};
        w_mask = '0;
        w_thr  = 1'b0;
        if (w_q inside {[4'd1:4'd7]}) begin
            w_mask = 7'((8'd1 << (4'd8 - w_q)) - 8'd1);
            w_thr  = (w_z[6:0] & w_mask) == 7'd0;
        end else if (w_q inside {[4'd8:4'd13]}) begin
            w_mask = 7'((8'd1 << (w_q - 4'd6)) - 8'd1);
            w_thr  = (w_z[6:0] & w_mask) != 7'd0;
        end else if (w_q inside {4'd14, 4'd15}) begin
            w_thr = 1'b1;
        end
        w_in_img = (32'(w_pl.pixel_x) < IMG_WIDTH) && (32'(w_pl.pixel_y) < IMG_HEIGHT);
        w_draw   = w_thr && w_in_img;
        w_bidx   = 32'(w_pl.pixel_x[7:2]) + 32'(w_pl.pixel_y) * 32'(IMG_WIDTH / 4);
    end

    t_pix_out r_out;

    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) begin
            r_out.draw        <= w_draw;
            r_out.byte_index  <= w_bidx[12:0];
            r_out.lane        <= w_pl.pixel_x[1:0];
            r_out.pixel_color <= w_draw ? r_color : 2'd0;
            r_out.noise_level <= w_level;
        end
    end

    assign o_result = r_out;

    // A blank pixel never carries a colour.
    a_blank_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.draw |-> o_result.pixel_color == 2'd0)
        else $error("undrawn pixel carries a colour");

    // The lowest level band never draws.
    a_low_band_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.noise_level[7:4] == 4'd0 |-> !o_result.draw)
        else $error("pixel drawn in the lowest level band");

    // Input back-pressure only arises when every stage is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld) && !i_ready)
        else $error("input stalled while the pipeline has a free stage");

endmodule

`default_nettype wire

// File: tb/perlin_noise_dither_pixel_tb.sv
// Self-checking testbench for the noise dither pixel block, with a predicting scoreboard.
`timescale 1ns / 100ps

module perlin_noise_dither_pixel_tb;
    import pndp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    class pixel_scoreboard;
        t_pix_out          expected_pix[$];
        int                errors;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic [15:0]       shift_amt;
        logic [23:0]       scale_val;
        logic [1:0]        colour;
        logic [15:0]       qsin[0:64];

        function new();
            longint unsigned x, x2, term;
            longint          acc;
            longint unsigned r;
            errors    = 0;
            off_x     = 0;
            off_y     = 0;
            shift_amt = 0;
            scale_val = 24'd655;
            colour    = 2'd1;
            for (int k = 0; k <= 64; k++) begin
                x    = (64'd3373259422 * longint'(k)) / 128;
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                for (int n = 1; n <= 7; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        acc = acc - longint'(term);
                    end else begin
                        acc = acc + longint'(term);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                r = (longint'(acc) + 32768) >> 16;
                if (r > 16384) begin
                    r = 16384;
                end
                qsin[k] = r[15:0];
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                CFG_OFFSET_X: begin
                    off_x = {{16{data[15]}}, data[15:0]};
                end
                CFG_OFFSET_Y: begin
                    off_y = {{16{data[15]}}, data[15:0]};
                end
                CFG_SHIFT: begin
                    shift_amt = data[15:0];
                end
                CFG_SCALE: begin
                    scale_val = data;
                end
                CFG_COLOR: begin
                    colour = data[1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function longint gradient_dot(logic [15:0] gx, logic [15:0] gy, longint dx, longint dy);
            logic [31:0] a, b;
            logic [7:0]  idx;
            logic [5:0]  k;
            longint      c, s;
            a = {{16{gx[15]}}, gx};
            b = {{16{gy[15]}}, gy};
            a = a * 32'd3284157443;
            b = b ^ ((a << 8) | (a >> 8));
            b = b * 32'd1911520717;
            a = a ^ ((b << 8) | (b >> 8));
            a = a * 32'd2048419325;
            idx = a[31:24];
            k = idx[5:0];
            case (idx[7:6])
                2'd0: begin
                    s = qsin[k];
                    c = qsin[64 - k];
                end
                2'd1: begin
                    s = qsin[64 - k];
                    c = -longint'(qsin[k]);
                end
                2'd2: begin
                    s = -longint'(qsin[k]);
                    c = -longint'(qsin[64 - k]);
                end
                default: begin
                    s = -longint'(qsin[64 - k]);
                    c = qsin[k];
                end
            endcase
            return dx * c + dy * s;
        endfunction

        function longint blend(longint a, longint b, longint w);
            return a + (((b - a) * w) >>> 16);
        endfunction

        function longint octave(longint cx, longint cy);
            logic [15:0] x0, y0, x1, y1;
            longint      fx, fy, top, bot, v, gxl, gyl;
            gxl = cx >>> 16;
            gyl = cy >>> 16;
            x0  = gxl[15:0];
            y0  = gyl[15:0];
            x1  = x0 + 16'd1;
            y1  = y0 + 16'd1;
            fx  = cx & 64'hFFFF;
            fy  = cy & 64'hFFFF;
            top = blend(gradient_dot(x0, y0, fx, fy), gradient_dot(x1, y0, fx - 65536, fy), fx);
            bot = blend(gradient_dot(x0, y1, fx, fy - 65536),
                        gradient_dot(x1, y1, fx - 65536, fy - 65536), fx);
            v = blend(top, bot, fy);
            return (v >>> 1) + (longint'(1) << 29);
        endfunction

        function t_pix_out predict_pixel(t_pix_in p);
            t_pix_out    r;
            longint      xx, yy, sc, t, lvl;
            logic [3:0]  q;
            logic [15:0] z;
            logic        hit;
            xx  = longint'(p.pixel_x) + longint'(off_x) + longint'(shift_amt);
            yy  = longint'(p.pixel_y) + longint'(off_y) + longint'(shift_amt);
            sc  = longint'(scale_val);
            t   = octave(xx * sc, yy * sc * 2) + (octave(xx * sc * 4, yy * sc * 4) >>> 2)
                  + (octave(xx * sc * 8, yy * sc * 8) >>> 3);
            lvl = (t <= 0) ? 0 : ((t * 255) >>> 31);
            if (lvl > 255) begin
                lvl = 255;
            end
            q = lvl[7:4];
            z = 16'(p.pixel_x) + 16'(p.pixel_y);
            if (q == 0) begin
                hit = 1'b0;
            end else if (q <= 7) begin
                hit = (z & ((16'd1 << (8 - q)) - 16'd1)) == 0;
            end else if (q <= 13) begin
                hit = (z & ((16'd1 << (q - 6)) - 16'd1)) != 0;
            end else begin
                hit = 1'b1;
            end
            if (p.pixel_x >= 256 || p.pixel_y >= 128) begin
                hit = 1'b0;
            end
            r.draw        = hit;
            r.byte_index  = 13'(p.pixel_x >> 2) + 13'(p.pixel_y) * 13'd64;
            r.lane        = p.pixel_x[1:0];
            r.pixel_color = hit ? colour : 2'd0;
            r.noise_level = lvl[7:0];
            return r;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void note_pixel(t_pix_in p);
            expected_pix.push_back(predict_pixel(p));
        endfunction

        task check_result(t_pix_out got);
            t_pix_out exp;
            if (expected_pix.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            exp = expected_pix.pop_front();
            if (got.draw !== exp.draw)
                report($sformatf("draw %0d, expected %0d", got.draw, exp.draw));
            if (got.byte_index !== exp.byte_index)
                report($sformatf("byte_index %0d, expected %0d", got.byte_index, exp.byte_index));
            if (got.lane !== exp.lane)
                report($sformatf("lane %0d, expected %0d", got.lane, exp.lane));
            if (got.pixel_color !== exp.pixel_color)
                report($sformatf("pixel_color %0d, expected %0d",
                                 got.pixel_color, exp.pixel_color));
            if (got.noise_level !== exp.noise_level)
                report($sformatf("noise_level %0d, expected %0d",
                                 got.noise_level, exp.noise_level));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_pix_in     i_pixel = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_pix_out    o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_OFFSET_X;
    logic [23:0] i_cfg_data = '0;

    pixel_scoreboard sb = new();
    bit  quiet_phase = 1'b0;
    int  idle_cycles = 0;

    perlin_noise_dither_pixel u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result monitor and watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_result);
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (quiet_phase || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    task automatic send_pixel(logic [7:0] px, logic [6:0] py);
        t_pix_in p;
        p.pixel_x = px;
        p.pixel_y = py;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(p);
    endtask

    // Holds off until the pipeline has drained completely.
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (sb.expected_pix.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_setting(logic [15:0] ox, logic [15:0] oy, logic [15:0] sh,
                                logic [23:0] sc, logic [1:0] col);
        drain_pipe();
        write_reg(CFG_OFFSET_X, {8'd0, ox});
        write_reg(CFG_OFFSET_Y, {8'd0, oy});
        write_reg(CFG_SHIFT, {8'd0, sh});
        write_reg(CFG_SCALE, sc);
        write_reg(CFG_COLOR, {22'd0, col});
    endtask

    task automatic random_pixels(int count);
        repeat (count) send_pixel(8'($urandom), 7'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners and bit patterns under the reset settings.
        send_pixel(8'd0, 7'd0);
        send_pixel(8'd255, 7'd127);
        send_pixel(8'd255, 7'd0);
        send_pixel(8'd0, 7'd127);
        send_pixel(8'hAA, 7'h55);
        send_pixel(8'h55, 7'h2A);
        send_pixel(8'd1, 7'd1);
        send_pixel(8'd128, 7'd64);

        // Extremes: grid wrap through large coordinates, zero and full scale.
        load_setting(16'h7FFF, 16'h7FFF, 16'hFFFF, 24'hFFFFFF, 2'd3);
        send_pixel(8'd255, 7'd127);
        send_pixel(8'd0, 7'd0);
        send_pixel(8'd17, 7'd90);
        load_setting(16'h8000, 16'h8000, 16'd0, 24'd0, 2'd0);
        send_pixel(8'd0, 7'd0);
        send_pixel(8'd255, 7'd127);
        load_setting(16'h8000, 16'h7FFF, 16'h8000, 24'h010000, 2'd2);
        send_pixel(8'd3, 7'd5);
        send_pixel(8'd200, 7'd100);

        load_setting(16'd0, 16'd0, 16'd0, 24'd655, 2'd1);
        random_pixels(200);
        load_setting(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom_range(0, 8000)),
                     2'($urandom));
        random_pixels(200);
        load_setting(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom), 2'($urandom));
        random_pixels(150);
        load_setting(16'($urandom), 16'($urandom), 16'd0, 24'($urandom_range(200, 3000)),
                     2'($urandom));
        random_pixels(150);

        // Closing stretch without idling on either side.
        load_setting(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom_range(0, 20000)),
                     2'($urandom));
        quiet_phase = 1'b1;
        random_pixels(200);
        drain_pipe();

        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/pndp_pkg.sv
rtl/pndp_octave.sv
rtl/perlin_noise_dither_pixel.sv
tb/perlin_noise_dither_pixel_tb.sv
